/* hdl/inclusive_day_count_between_dates_defines.svh */
// Assertion macros shared by the day count RTL.
// Depends on nothing; the files that check behavior include it.
`ifndef INCLUSIVE_DAY_COUNT_BETWEEN_DATES_DEFINES_SVH
`define INCLUSIVE_DAY_COUNT_BETWEEN_DATES_DEFINES_SVH
`ifndef SYNTHESIS
`define IDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define IDC_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define IDC_ASSERT(lbl, clk, rst_n, prop)
`define IDC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hdl/idc_pkg.sv */
// Types, constants and the month table of the day count block.
// Depends on nothing.
package idc_pkg;

	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned HUNDRED       = 100;
	localparam int unsigned RECIP_100     = 5243;  // ceil(2^19 / 100)
	localparam int unsigned RECIP_SHIFT   = 19;
	localparam int unsigned COUNT_MAX     = 4194303;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [4:0]  end_day;
		logic [3:0]  end_month;
		logic [13:0] end_year;
	} date_pair_t;

	typedef struct packed {
		logic [21:0] day_count;
		logic        order_error;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture an input transaction
		logic sel_end;  // work on the end date
		logic calc_a;   // register the products
		logic calc_b;   // register the serial day number
		logic out_load; // register the result
	} dp_cmd_t;

	// Days before month index (month - 1), common year; index 12 is a full year.
	function automatic logic [8:0] days_before_month(input logic [3:0] idx);
		logic [8:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

/* hdl/idc_stream_if.sv */
// Valid/ready channel carrying one payload struct.
// Depends on idc_pkg for the payload types.
interface idc_stream_if import idc_pkg::*; #(parameter type payload_t = date_pair_t);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/idc_datapath.sv */
// Datapath: shared serial day unit, serial registers and result register.
// Depends on idc_pkg.
module idc_datapath import idc_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic       clk,
	input  dp_cmd_t    cmd,
	input  date_pair_t in_data,
	output result_t    result
);

	date_pair_t dates_q;

	// stage A selection and clamping
	logic [4:0]  day_sel;
	logic [3:0]  month_sel;
	logic [13:0] year_sel;
	logic [13:0] year_c;
	logic [13:0] prior;
	logic [3:0]  month_idx;

	// stage A registers
	logic [22:0] p365_q;
	logic [26:0] p100_q;
	logic [24:0] p400_q;
	logic [26:0] py_q;
	logic [11:0] q4_q;
	logic [13:0] year_q;
	logic [9:0]  day_month_q;
	logic        late_q;

	// stage B
	logic [7:0]  q100;
	logic [5:0]  q400;
	logic [7:0]  yq100;
	logic [14:0] yq_x100;
	logic        rem100_zero;
	logic        leap;
	logic [22:0] serial;
	logic [22:0] start_ser_q;
	logic [22:0] end_ser_q;

	logic [23:0] diff;
	logic [23:0] cnt;
	result_t     res_d;
	result_t     res_q;

	always_comb begin
		day_sel   = cmd.sel_end ? dates_q.end_day   : dates_q.start_day;
		month_sel = cmd.sel_end ? dates_q.end_month : dates_q.start_month;
		year_sel  = cmd.sel_end ? dates_q.end_year  : dates_q.start_year;

		if (year_sel == 14'd0) begin
			year_c = 14'd1;
		end else if ({3'b000, year_sel} > 17'(MAX_YEAR)) begin
			year_c = 14'(MAX_YEAR);
		end else begin
			year_c = year_sel;
		end
		prior = year_c - 14'd1;

		if (month_sel == 4'd0) begin
			month_idx = 4'd0;
		end else if (month_sel > 4'd13) begin
			month_idx = 4'd12;
		end else begin
			month_idx = month_sel - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dates_q <= in_data;
		end
		if (cmd.calc_a) begin
			p365_q      <= 23'(prior) * 23'(DAYS_PER_YEAR);
			p100_q      <= 27'(prior) * 27'(RECIP_100);
			p400_q      <= 25'(prior[13:2]) * 25'(RECIP_100);
			py_q        <= 27'(year_c) * 27'(RECIP_100);
			q4_q        <= prior[13:2];
			year_q      <= year_c;
			day_month_q <= 10'(days_before_month(month_idx)) + 10'(day_sel);
			late_q      <= (month_sel >= 4'd3);
		end
	end

	always_comb begin
		q100        = p100_q[26:RECIP_SHIFT];
		q400        = p400_q[24:RECIP_SHIFT];
		yq100       = py_q[26:RECIP_SHIFT];
		yq_x100     = 15'(yq100) * 15'(HUNDRED);
		rem100_zero = ({1'b0, year_q} == yq_x100);
		// divisible by 400 is divisible by 100 with a quotient divisible by 4
		leap = ((year_q[1:0] == 2'd0) && !rem100_zero)
			|| (rem100_zero && (yq100[1:0] == 2'd0));
		serial = p365_q + 23'(q4_q) - 23'(q100) + 23'(q400)
			+ 23'(day_month_q) + 23'(leap && late_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_b) begin
			if (cmd.sel_end) begin
				end_ser_q <= serial;
			end else begin
				start_ser_q <= serial;
			end
		end
	end

	always_comb begin
		diff = {1'b0, end_ser_q} - {1'b0, start_ser_q};
		cnt  = diff + 24'd1;
		if (diff[23]) begin
			res_d.day_count   = '0;
			res_d.order_error = 1'b1;
		end else begin
			res_d.day_count   = (cnt > 24'(COUNT_MAX)) ? 22'(COUNT_MAX) : cnt[21:0];
			res_d.order_error = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

/* hdl/idc_controller.sv */
// Controller: sequences the shared serial unit over both dates and owns
// the output valid flag. Depends on idc_pkg and the assertion macros.
`include "inclusive_day_count_between_dates_defines.svh"
module idc_controller import idc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SA   = 6'b000010,
		ST_SB   = 6'b000100,
		ST_EA   = 6'b001000,
		ST_EB   = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.load     = in_fire;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_SA;
				end
			end
			ST_SA: begin
				cmd.calc_a = 1'b1;
				state_d    = ST_SB;
			end
			ST_SB: begin
				cmd.calc_b = 1'b1;
				state_d    = ST_EA;
			end
			ST_EA: begin
				cmd.sel_end = 1'b1;
				cmd.calc_a  = 1'b1;
				state_d     = ST_EB;
			end
			ST_EB: begin
				cmd.sel_end = 1'b1;
				cmd.calc_b  = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output slot is free or drains now
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`IDC_ASSERT(a_accept_starts, clk, arst_n, in_fire |=> (state_q == ST_SA))
	`IDC_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !out_ready)
	`IDC_ASSERT(a_load_shows, clk, arst_n, cmd.out_load |=> out_valid_q)

endmodule

/* hdl/inclusive_day_count_between_dates.sv */
// Top level of the inclusive Gregorian day count block.
// Depends on idc_pkg, idc_stream_if, idc_controller and idc_datapath.
//
// Usage:
//   dates  : sink channel; one transaction carries a start and an end date
//            as day, month and year fields (not checked for validity).
//   result : source channel; one transaction per date pair with day_count,
//            the inclusive count (equal dates give 1), and order_error, set
//            with a zero count when the end date precedes the start date.
//   Years clamp to 1..MAX_YEAR; counts too wide for day_count saturate.
// Sequencing:
//   An accepted pair goes through the sequencer states SA, SB, EA, EB and
//   FIN. The single serial day unit handles the start date and then the
//   end date, each as products (SA, EA) and then sum (SB, EB), and FIN
//   compares and loads the output register; a new pair is taken only after
//   that load. dates.ready is high only while the sequencer is idle.
// Reset: arst_n clears the sequencer and the output valid flag at once;
//   no result is pending afterwards.
// Stall: a result waits in the output register while result.ready is low;
//   the next pair is still accepted and computed, and holds before loading
//   until the output register is taken.
module inclusive_day_count_between_dates import idc_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic         clk,
	input  logic         arst_n,
	idc_stream_if.sink   dates,
	idc_stream_if.source result
);

	dp_cmd_t cmd;
	result_t res;

	idc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dates.valid),
		.in_ready  (dates.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	idc_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.in_data (dates.data),
		.result  (res)
	);

	// drive the result payload from the datapath output register
	assign result.data = res;

endmodule

/* tb/day_count_checker.sv */
// Scoreboard for the inclusive day count block: predicts one result per date
// pair and compares it with what comes out of the result channel.
// Depends on idc_pkg for the date pair and result types.
module day_count_checker import idc_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dates_valid,
	input  logic       dates_ready,
	input  date_pair_t dates_data,
	input  logic       result_valid,
	input  logic       result_ready,
	input  result_t    result_data,
	output int         failures,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Days ahead of each month in a common year; slot 12 is a whole year.
	localparam logic [12:0][8:0] DAYS_AHEAD = {
		9'd365, 9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
		9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
	};
	localparam logic [21:0] COUNT_CEIL = '1;

	result_t expected_counts[$];
	int      mismatch_total;

	function automatic bit leap_year(input longint unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// Serial day number; years clamp to 1..MAX_YEAR, months to 1..13.
	function automatic longint unsigned day_number(input logic [4:0] d,
			input logic [3:0] m, input logic [13:0] y);
		longint unsigned yy;
		longint unsigned mm;
		longint unsigned prior;
		longint unsigned num;
		yy = y;
		if (yy < 1)
			yy = 1;
		if (yy > MAX_YEAR)
			yy = MAX_YEAR;
		mm = m;
		if (mm < 1)
			mm = 1;
		if (mm > 13)
			mm = 13;
		prior = yy - 1;
		num = prior * 365 + prior / 4 - prior / 100 + prior / 400;
		num += DAYS_AHEAD[4'(mm - 1)];
		if (mm >= 3 && leap_year(yy))
			num += 1;
		num += d;
		return num;
	endfunction

	function automatic result_t predict_count(input date_pair_t p);
		longint unsigned start_num;
		longint unsigned end_num;
		longint unsigned span;
		result_t r;
		start_num = day_number(p.start_day, p.start_month, p.start_year);
		end_num   = day_number(p.end_day, p.end_month, p.end_year);
		r.day_count   = '0;
		r.order_error = 1'b0;
		if (end_num < start_num) begin
			r.order_error = 1'b1;
		end else begin
			span = end_num - start_num + 1;
			r.day_count = (span > COUNT_CEIL) ? COUNT_CEIL : span[21:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (dates_valid && dates_ready)
				expected_counts.push_back(predict_count(dates_data));
			if (result_valid && result_ready) begin
				if (expected_counts.size() == 0) begin
					$error("unexpected result: day_count %0d, order_error %0b",
						result_data.day_count, result_data.order_error);
					mismatch_total++;
				end else begin
					want = expected_counts.pop_front();
					if (result_data.day_count !== want.day_count) begin
						$error("day_count: expected %0d, actual %0d",
							want.day_count, result_data.day_count);
						mismatch_total++;
					end
					if (result_data.order_error !== want.order_error) begin
						$error("order_error: expected %0b, actual %0b",
							want.order_error, result_data.order_error);
						mismatch_total++;
					end
				end
			end
		end
		// Publish after the edge so readers at the next edge see this one.
		failures <= mismatch_total;
		pending  <= expected_counts.size();
	end

endmodule

/* tb/tb_top.sv */
// Testbench top for the inclusive day count block: clock, reset, date pair
// stimulus, result back-pressure, watchdog and the final verdict.
// Depends on idc_pkg, idc_stream_if, the block and day_count_checker.
module tb_top import idc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_YEAR         = 9999;
	localparam int          PAIR_BITS        = $bits(date_pair_t);
	localparam int          RANDOM_PER_PHASE = 617;
	localparam int          LONG_HOLD        = 80;   // receiver hold-off, in cycles
	localparam int          HOLD_AT          = 150;  // item index that starts the hold-off
	localparam int          DRAIN_AT         = 400;  // item index where the sender waits
	localparam int          DRAIN_CYCLES     = 12;
	localparam int          WATCHDOG_LIMIT   = 2000;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   send_idle;    // percent of cycles the sender idles before a transaction
	int   recv_idle;    // percent of cycles the receiver drops ready
	int   hold_req;     // bumped by the stimulus to ask for one long hold-off
	int   quiet_cycles;

	idc_stream_if                        dates_if ();
	idc_stream_if #(.payload_t(result_t)) res_if ();

	inclusive_day_count_between_dates #(
		.MAX_YEAR(MAX_YEAR)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.dates (dates_if),
		.result(res_if)
	);

	day_count_checker #(
		.MAX_YEAR(MAX_YEAR)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.dates_valid (dates_if.valid),
		.dates_ready (dates_if.ready),
		.dates_data  (dates_if.data),
		.result_valid(res_if.valid),
		.result_ready(res_if.ready),
		.result_data (res_if.data),
		.failures    (failures),
		.pending     (pending)
	);

	// 4 ns period, starting low.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Build a date pair from plain integers; fields take the low bits.
	function automatic date_pair_t pair_of(input int sd, input int sm, input int sy,
			input int ed, input int em, input int ey);
		date_pair_t p;
		p.start_day   = 5'(sd);
		p.start_month = 4'(sm);
		p.start_year  = 14'(sy);
		p.end_day     = 5'(ed);
		p.end_month   = 4'(em);
		p.end_year    = 14'(ey);
		return p;
	endfunction

	// Mostly well-formed dates in forward order, with some raw bit noise,
	// near pairs that often tie or flip order, and leap-day neighborhoods.
	function automatic date_pair_t random_pair();
		date_pair_t  p;
		logic [13:0] yr;
		int          kind;
		kind = $urandom_range(9, 0);
		p = pair_of($urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(9999, 1),
			$urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(9999, 1));
		case (kind)
			0, 1: begin
				// Raw noise: every bit of every field toggles, out-of-range values too.
				p = PAIR_BITS'({$urandom(), $urandom()});
			end
			2, 3, 4: begin
				// Put the later year at the end.
				if (p.start_year > p.end_year)
					{p.start_year, p.end_year} = {p.end_year, p.start_year};
			end
			5: begin
				// Leave order as drawn; about half raise the order flag.
			end
			6, 7, 8: begin
				// Short spans: same or next couple of years, often the same month.
				p.end_year = p.start_year + 14'($urandom_range(2, 0));
				if ($urandom_range(1, 0) == 1)
					p.end_month = p.start_month;
			end
			default: begin
				// Around February 29 in century, quad-century and ordinary leap years.
				case ($urandom_range(6, 0))
					0:       yr = 14'd1600;
					1:       yr = 14'd1700;
					2:       yr = 14'd1900;
					3:       yr = 14'd2000;
					4:       yr = 14'd2100;
					5:       yr = 14'd2400;
					default: yr = 14'(4 * $urandom_range(2499, 1));
				endcase
				p.start_year  = yr;
				p.end_year    = yr + 14'($urandom_range(1, 0));
				p.start_month = 4'd2;
				p.start_day   = 5'($urandom_range(29, 27));
				p.end_month   = 4'($urandom_range(3, 2));
				p.end_day     = 5'($urandom_range(2, 0));
			end
		endcase
		return p;
	endfunction

	// Offer one transaction on the dates channel: idle a random number of
	// cycles, raise valid with the payload, hold it until the handshake.
	// Return at the edge that accepted it, with valid still high.
	task automatic send_dates(input date_pair_t p);
		while ($urandom_range(99, 0) < send_idle) begin
			dates_if.valid <= 1'b0;
			@(posedge clk);
		end
		dates_if.valid <= 1'b1;
		dates_if.data  <= p;
		@(posedge clk);
		while (!dates_if.ready)
			@(posedge clk);
	endtask

	// Drop valid and hold until the checker has nothing outstanding. The
	// checker publishes its count after each edge, so look from the next edge.
	task automatic drain_results();
		dates_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result channel receiver: random ready, plus a long hold-off counted
	// here whenever the stimulus bumps hold_req.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99, 0) >= recv_idle);
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (dates_if.valid && dates_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n         <= 1'b0;
		dates_if.valid <= 1'b0;
		dates_if.data  <= '0;
		hold_req       <= 0;
		send_idle = 12;
		recv_idle = 66;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: same day, full range, field extremes, leap rules,
		// invalid days and months, clamped years, order flag.
		send_dates(pair_of(1, 1, 1, 1, 1, 1));                 // same day gives 1
		send_dates(pair_of(1, 1, 1, 31, 12, 9999));            // widest valid span
		send_dates(pair_of(0, 0, 0, 31, 15, 16383));           // all zeros to all ones
		send_dates(pair_of(31, 15, 16383, 0, 0, 0));           // reversed: order flag
		send_dates(pair_of(29, 2, 2000, 1, 3, 2000));          // divisible by 400: leap
		send_dates(pair_of(28, 2, 1900, 1, 3, 1900));          // divisible by 100: common
		send_dates(pair_of(28, 2, 2024, 1, 3, 2024));          // ordinary leap year
		send_dates(pair_of(28, 2, 2023, 1, 3, 2023));          // ordinary common year
		send_dates(pair_of(31, 1, 2000, 0, 2, 2000));          // day zero ties previous day
		send_dates(pair_of(0, 2, 2000, 30, 1, 2000));          // one day backwards
		send_dates(pair_of(1, 1, 2001, 31, 12, 2000));         // backwards across a year
		send_dates(pair_of(31, 12, 2000, 1, 1, 2001));         // forward across a year
		send_dates(pair_of(1, 13, 1999, 1, 1, 2000));          // month past twelve
		send_dates(pair_of(1, 0, 2000, 1, 1, 2000));           // month zero acts as January
		send_dates(pair_of(15, 6, 10000, 15, 6, 9999));        // year above the maximum
		send_dates(pair_of(1, 1, 0, 1, 1, 1));                 // year zero
		send_dates(pair_of(31, 12, 9999, 31, 12, 9999));       // last day, same day
		send_dates(pair_of(1, 1, 2100, 31, 12, 2100));         // century year: 365
		send_dates(pair_of(1, 1, 2400, 31, 12, 2400));         // quad century: 366
		send_dates(pair_of(17, 10, 8191, 5, 4, 4096));         // year bit patterns
		send_dates(pair_of(10, 5, 4095, 21, 10, 12288));
		send_dates(pair_of(31, 15, 9999, 31, 15, 9999));       // invalid month, same day

		// Random, in three idling phases: slow receiver, slow sender, no idling.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 12;
					recv_idle = 66;
				end
				1: begin
					send_idle = 66;
					recv_idle = 12;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Stall the receiver while the sender keeps going, to fill the block.
				if (n == HOLD_AT && phase != 1)
					hold_req <= hold_req + 1;
				// Pause the sender until every outstanding result is back.
				if (n == DRAIN_AT)
					drain_results();
				send_dates(random_pair());
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/idc_pkg.sv
hdl/idc_stream_if.sv
hdl/idc_datapath.sv
hdl/idc_controller.sv
hdl/inclusive_day_count_between_dates.sv
tb/day_count_checker.sv
tb/tb_top.sv
